// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property forms for the shift register chain driver checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define SRCD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define SRCD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/srcd_pkg.sv -----
// ----------------------------------------------------------------------------
// srcd_pkg
// Types and fixed constants of the shift register chain driver.
// ----------------------------------------------------------------------------
package srcd_pkg;

   // Fixed field widths of the request and configuration ports.
   localparam int CNT_W    = 4;   // chips_in_use and chip counters
   localparam int CHIP_W   = 3;   // chip_index
   localparam int BITIDX_W = 4;   // bit_index
   localparam int WORD_W   = 16;  // word_value

   typedef enum logic [2:0] {
      CMD_TICK  = 3'd0,
      CMD_WRITE = 3'd1,
      CMD_SET   = 3'd2,
      CMD_CLEAR = 3'd3,
      CMD_SHIFT = 3'd4
   } cmd_type;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'b001,
      PH_WRITE = 3'b010,
      PH_LATCH = 3'b100
   } phase_type;

   // One edit request handed from the request stage to the image store.
   typedef struct packed {
      logic                valid;
      cmd_type             cmd;
      logic [CHIP_W-1:0]   chip;
      logic [BITIDX_W-1:0] bit_idx;
      logic [WORD_W-1:0]   word;
   } edit_type;

endpackage

// ----- sv/srcd_image_store.sv -----
// ----------------------------------------------------------------------------
// srcd_image_store
// Output image words and the changed flag; applies write, set, clear and
// shift edits.
// ----------------------------------------------------------------------------
module srcd_image_store #(
   parameter int WORD_BITS = 16,
   parameter int DEPTH_CAP = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  srcd_pkg::edit_type           edit,
   input  logic [srcd_pkg::CNT_W-1:0]   depth,
   input  logic                         snapshot_take,
   output logic [WORD_BITS-1:0]         image_words [DEPTH_CAP],
   output logic                         image_changed
);
   import srcd_pkg::*;

   localparam int BIT_W = $clog2(WORD_BITS);

   logic [WORD_BITS-1:0] image_ff [DEPTH_CAP];
   logic [WORD_BITS-1:0] image_in [DEPTH_CAP];
   logic                 changed_ff;
   logic                 changed_in;
   logic                 chip_ok;
   logic                 bit_ok;
   logic [BIT_W-1:0]     bit_sel;

   assign chip_ok = {1'b0, edit.chip} < depth;
   assign bit_ok  = {1'b0, edit.bit_idx} < (BITIDX_W + 1)'(WORD_BITS);
   assign bit_sel = edit.bit_idx[BIT_W-1:0];

   always_comb begin
      image_in   = image_ff;
      changed_in = changed_ff;
      if (snapshot_take) begin
         changed_in = 1'b0;
      end
      if (edit.valid) begin
         case (edit.cmd)
            CMD_WRITE: begin
               if (chip_ok) begin
                  for (int i = 0; i < DEPTH_CAP; i++) begin
                     if (CNT_W'(i) == {1'b0, edit.chip}) begin
                        image_in[i] = edit.word[WORD_BITS-1:0];
                     end
                  end
                  changed_in = 1'b1;
               end
            end
            CMD_SET, CMD_CLEAR: begin
               if (chip_ok && bit_ok) begin
                  for (int i = 0; i < DEPTH_CAP; i++) begin
                     if (CNT_W'(i) == {1'b0, edit.chip}) begin
                        image_in[i][bit_sel] = (edit.cmd == CMD_SET);
                     end
                  end
                  changed_in = 1'b1;
               end
            end
            CMD_SHIFT: begin
               for (int i = 0; i < DEPTH_CAP; i++) begin
                  if (CNT_W'(i) < depth) begin
                     image_in[i] = image_ff[i] << 1;
                  end
               end
               changed_in = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH_CAP; i++) begin
            image_ff[i] <= '0;
         end
         changed_ff <= 1'b0;
      end else begin
         image_ff   <= image_in;
         changed_ff <= changed_in;
      end
   end

   assign image_words   = image_ff;
   assign image_changed = changed_ff;

endmodule

// ----- sv/shift_register_chain_driver_unit.sv -----
// ----------------------------------------------------------------------------
// shift_register_chain_driver_unit
// Serial driver for a chain of latch-type shift register chips. Requests edit
// an output image (write a word, set or clear a bit, shift every in-use word
// left by one) or tick the output sequencer. When a tick finds the sequencer
// idle and the image changed, the in-use words are copied to a staging buffer
// and sent out: the serial clock toggles on every tick, each falling half
// drives the next staged bit (chip 0 bit 0 first), then the latch pin pulses
// high for one tick and low for one tick. Edits are taken while a transfer
// runs. Every request gives exactly one response carrying the clock, latch
// and data pin levels and the busy flag after that request. One request is
// taken per cycle while responses drain; it passes the request register, then
// the state update loading the response register. The response register has
// its own valid, so a stalled response only holds the request stage once both
// are full. chips_in_use is to be written through the csr port only while the
// unit is idle, which it does not enforce; values above chip capacity saturate.
// ----------------------------------------------------------------------------
module shift_register_chain_driver_unit #(
   parameter int MAX_CHIPS = 8,
   parameter int WORD_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [2:0]                      req_cmd,
   input  logic [srcd_pkg::CHIP_W-1:0]     req_chip_index,
   input  logic [srcd_pkg::BITIDX_W-1:0]   req_bit_index,
   input  logic [srcd_pkg::WORD_W-1:0]     req_word_value,
   // response channel
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_clock_pin,
   output logic                            rsp_latch_pin,
   output logic                            rsp_data_pin,
   output logic                            rsp_busy_res,
   // configuration
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [srcd_pkg::CNT_W-1:0]      csr_chips_in_use
);
   import srcd_pkg::*;

   // chips_in_use is 4 bits, so no more than 15 words can ever be in use.
   localparam int CNT_MAX   = (1 << CNT_W) - 1;
   localparam int DEPTH_CAP = (MAX_CHIPS < CNT_MAX) ? MAX_CHIPS : CNT_MAX;
   localparam int IDX_W     = (DEPTH_CAP > 1) ? $clog2(DEPTH_CAP) : 1;
   localparam int BIT_W     = $clog2(WORD_BITS);

   // ---------------------------------------------------------------------
   // Configuration register
   // ---------------------------------------------------------------------
   logic [CNT_W-1:0] chips_ff;
   logic [CNT_W-1:0] depth;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         chips_ff <= CNT_W'(8);
      end else if (csr_valid && csr_ready) begin
         chips_ff <= csr_chips_in_use;
      end
   end

   // Saturate the chip count to the chain capacity.
   assign depth = (chips_ff > CNT_W'(DEPTH_CAP)) ? CNT_W'(DEPTH_CAP) : chips_ff;

   // ---------------------------------------------------------------------
   // Request stage
   // ---------------------------------------------------------------------
   logic                s1_valid_ff;
   logic                s1_go;
   logic [2:0]          s1_cmd_ff;
   logic [CHIP_W-1:0]   s1_chip_ff;
   logic [BITIDX_W-1:0] s1_bit_ff;
   logic [WORD_W-1:0]   s1_word_ff;
   logic                rsp_valid_ff;
   cmd_type             s1_cmd;

   // Advance the request stage whenever the response register is free or
   // being drained this cycle.
   assign s1_go     = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_go;
   assign s1_cmd    = cmd_type'(s1_cmd_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_cmd_ff  <= req_cmd;
         s1_chip_ff <= req_chip_index;
         s1_bit_ff  <= req_bit_index;
         s1_word_ff <= req_word_value;
      end
   end

   // ---------------------------------------------------------------------
   // Output image
   // ---------------------------------------------------------------------
   edit_type             edit;
   logic [WORD_BITS-1:0] image_words [DEPTH_CAP];
   logic                 image_changed;
   logic                 snapshot_take;

   assign edit.valid   = s1_go;
   assign edit.cmd     = s1_cmd;
   assign edit.chip    = s1_chip_ff;
   assign edit.bit_idx = s1_bit_ff;
   assign edit.word    = s1_word_ff;

   srcd_image_store #(
      .WORD_BITS (WORD_BITS),
      .DEPTH_CAP (DEPTH_CAP)
   ) u_image (
      .clock         (clock),
      .reset         (reset),
      .edit          (edit),
      .depth         (depth),
      .snapshot_take (snapshot_take),
      .image_words   (image_words),
      .image_changed (image_changed)
   );

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------
   phase_type            phase_ff;
   phase_type            phase_in;
   logic                 clock_ff;
   logic                 clock_in;
   logic                 latch_ff;
   logic                 latch_in;
   logic                 data_ff;
   logic                 data_in;
   logic [CNT_W-1:0]     chip_pos_ff;
   logic [CNT_W-1:0]     chip_pos_in;
   logic [BIT_W-1:0]     bit_pos_ff;
   logic [BIT_W-1:0]     bit_pos_in;
   logic [WORD_BITS-1:0] staged_ff [DEPTH_CAP];
   logic                 tick;
   logic [WORD_BITS-1:0] staged_word;

   assign tick        = s1_go && (s1_cmd == CMD_TICK);
   assign staged_word = staged_ff[chip_pos_ff[IDX_W-1:0]];

   always_comb begin
      phase_in      = phase_ff;
      clock_in      = clock_ff;
      latch_in      = latch_ff;
      data_in       = data_ff;
      chip_pos_in   = chip_pos_ff;
      bit_pos_in    = bit_pos_ff;
      snapshot_take = 1'b0;
      if (tick) begin
         unique case (phase_ff)
            PH_IDLE: begin
               // Take a snapshot only when there is something new to send.
               if (image_changed) begin
                  snapshot_take = 1'b1;
                  phase_in      = PH_WRITE;
               end
            end
            PH_WRITE: begin
               if (clock_ff) begin
                  // Falling half: drive the next bit, or finish the word run.
                  if (chip_pos_ff < depth) begin
                     data_in = staged_word[bit_pos_ff];
                     if (bit_pos_ff == BIT_W'(WORD_BITS - 1)) begin
                        bit_pos_in  = '0;
                        chip_pos_in = chip_pos_ff + 1'b1;
                     end else begin
                        bit_pos_in  = bit_pos_ff + 1'b1;
                     end
                  end else begin
                     bit_pos_in  = '0;
                     chip_pos_in = '0;
                     phase_in    = PH_LATCH;
                  end
                  clock_in = 1'b0;
               end else begin
                  clock_in = 1'b1;
               end
            end
            PH_LATCH: begin
               if (latch_ff) begin
                  latch_in = 1'b0;
                  phase_in = PH_IDLE;
               end else begin
                  latch_in = 1'b1;
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         clock_ff    <= 1'b0;
         latch_ff    <= 1'b0;
         data_ff     <= 1'b0;
         chip_pos_ff <= '0;
         bit_pos_ff  <= '0;
      end else begin
         phase_ff    <= phase_in;
         clock_ff    <= clock_in;
         latch_ff    <= latch_in;
         data_ff     <= data_in;
         chip_pos_ff <= chip_pos_in;
         bit_pos_ff  <= bit_pos_in;
      end
   end

   // Copy the in-use words; words beyond the chip count keep older values.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH_CAP; i++) begin
            staged_ff[i] <= '0;
         end
      end else if (snapshot_take) begin
         for (int i = 0; i < DEPTH_CAP; i++) begin
            if (CNT_W'(i) < depth) begin
               staged_ff[i] <= image_words[i];
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Response register
   // ---------------------------------------------------------------------
   logic rsp_clock_ff;
   logic rsp_latch_ff;
   logic rsp_data_ff;
   logic rsp_busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Load the pin levels as they stand after this request.
   always_ff @(posedge clock) begin
      if (s1_go) begin
         rsp_clock_ff <= clock_in;
         rsp_latch_ff <= latch_in;
         rsp_data_ff  <= data_in;
         rsp_busy_ff  <= (phase_in != PH_IDLE);
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_clock_pin = rsp_clock_ff;
   assign rsp_latch_pin = rsp_latch_ff;
   assign rsp_data_pin  = rsp_data_ff;
   assign rsp_busy_res  = rsp_busy_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
`include "assert_macros.svh"

   `SRCD_ASSERT_NOW(a_pins_exclusive, clock, reset, 1'b1, !(clock_ff && latch_ff), "serial clock and latch both high")
   `SRCD_ASSERT_NOW(a_idle_pins_low, clock, reset, phase_ff == PH_IDLE, !clock_ff && !latch_ff, "pin left high while idle")
   `SRCD_ASSERT_NEXT(a_latch_ends, clock, reset, tick && phase_ff == PH_LATCH && latch_ff, phase_ff == PH_IDLE, "latch pulse did not return to idle")

endmodule
